@@ sv/kfus_pkg.sv @@
// kfus_pkg: shared types and widths for the two-sensor kalman fusion block
// used by kfus_div and two_sensor_kalman_fusion; no dependencies
`default_nettype none

package kfus_pkg;

	localparam int VAL_W = 32;
	localparam int WGT_W = 31;
	localparam int DEN_W = 33;
	localparam int QUO_W = 33;
	localparam int NUM_W = 65;
	localparam int CNT_W = 6;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_FLOW_Q  = 3'd0;
	localparam logic [IDX_W-1:0] REG_FLOW_RA = 3'd1;
	localparam logic [IDX_W-1:0] REG_FLOW_RB = 3'd2;
	localparam logic [IDX_W-1:0] REG_WGT_Q   = 3'd3;
	localparam logic [IDX_W-1:0] REG_WGT_RA  = 3'd4;
	localparam logic [IDX_W-1:0] REG_WGT_RB  = 3'd5;

	localparam logic [1:0] SNS_FLOW_A = 2'd0;
	localparam logic [1:0] SNS_FLOW_B = 2'd1;
	localparam logic [1:0] SNS_WGT_A  = 2'd2;
	localparam logic [1:0] SNS_WGT_B  = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_FQ,
		ST_GROW_F,
		ST_MUL_W,
		ST_DROP_W,
		ST_MUL_WQ,
		ST_GROW_W,
		ST_SENSOR,
		ST_MUL_C,
		ST_START_C,
		ST_WAIT_C,
		ST_UPD_X,
		ST_MUL_P,
		ST_START_P,
		ST_WAIT_P,
		ST_NEXT,
		ST_CLAMP,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

@@ sv/two_sensor_kalman_fusion.sv @@
// two_sensor_kalman_fusion: two coupled scalar kalman filters, fixed point
// depends on kfus_pkg and kfus_div
//
// usage:
//   slave stream s_*: one item per measurement set; s_tuser is func
//   (1 init, 0 update), s_tdata holds flow_a, flow_b, weight_a, weight_b, dt.
//   master stream m_*: one result item per input item.
//   cfg_we/cfg_index/cfg_data write the six noise registers; index 6, 7 ignored.
// sequence and throughput:
//   init and zero-dt items: m_tvalid in the cycle after the accepting edge.
//   update items: prediction (flow variance, weight drop, weight variance),
//   then per enabled sensor a gain multiply and divide, the estimate update,
//   a variance multiply and divide; a disabled sensor (r = 0) is skipped; then a clamp.
//   s_tready is high only while idle, one item in flight at a time.
// reset: estimates clear, flow variance 1.0, weight variance 10.0,
//   registers to their defaults.
// stall: the result waits in the output register until m_tready; no new
//   item is accepted meanwhile.
`default_nettype none

module two_sensor_kalman_fusion #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// flow_a, flow_b, weight_a, weight_b, dt
	input  wire logic [159:0] s_tdata,
	// func
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// fused_flow, fused_weight, flow_variance, weight_variance, zero pad
	output logic [127:0]      m_tdata,
	// skipped
	output logic              m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import kfus_pkg::*;

	localparam logic [VAL_W-1:0] ONE_FX   = VAL_W'(64'd1 << FRAC_BITS);
	localparam logic [VAL_W-1:0] TENTH_FX = VAL_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [VAL_W-1:0] TEN_FX   = VAL_W'(64'd10 << FRAC_BITS);
	localparam logic [NUM_W-1:0] HALF_FX  = NUM_W'(65'd1 << (FRAC_BITS - 1));
	localparam logic [VAL_W:0]   WGT_MAX  = {2'b00, {WGT_W{1'b1}}};

	state_t state_q, state_d;

	logic [VAL_W-1:0] fq_q, ra_f_q, rb_f_q, wq_q, ra_w_q, rb_w_q;
	logic signed [VAL_W-1:0] flow_q, wgt_q;
	logic [VAL_W-1:0] fcov_q, wcov_q;
	logic signed [VAL_W-1:0] fa_q, fb_q, wa_q, wb_q;
	logic [VAL_W-1:0] dt_q;
	logic [1:0]       k_q;
	logic             skip_q;
	logic [NUM_W-1:0] prod_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] mag_q;
	logic             neg_q;

	logic [DEN_W-1:0] mul_a;
	logic [VAL_W-1:0] mul_b;
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic             div_busy, div_done;
	logic [QUO_W-1:0] div_quot;

	logic signed [VAL_W-1:0] x_sel, m_sel;
	logic [VAL_W-1:0] p_sel, r_sel;
	logic signed [DEN_W-1:0] d_val;
	logic [NUM_W-1:0] rnd_sum, inc;
	logic [NUM_W:0]   grow_f, grow_w;
	logic signed [NUM_W+1:0] w_drop;
	logic signed [DEN_W+1:0] x_new;
	logic [VAL_W-1:0] flow_abs;
	logic             accept;

	assign accept = s_tvalid && s_tready;

	// sensor selection
	always_comb begin
		unique case (k_q)
			SNS_FLOW_A: begin
				x_sel = flow_q; m_sel = fa_q; p_sel = fcov_q; r_sel = ra_f_q;
			end
			SNS_FLOW_B: begin
				x_sel = flow_q; m_sel = fb_q; p_sel = fcov_q; r_sel = rb_f_q;
			end
			SNS_WGT_A: begin
				x_sel = wgt_q; m_sel = wa_q; p_sel = wcov_q; r_sel = ra_w_q;
			end
			default: begin
				x_sel = wgt_q; m_sel = wb_q; p_sel = wcov_q; r_sel = rb_w_q;
			end
		endcase
	end

	assign d_val    = DEN_W'(m_sel) - DEN_W'(x_sel);
	assign flow_abs = flow_q[VAL_W-1] ? VAL_W'(-flow_q) : VAL_W'(flow_q);
	assign rnd_sum  = prod_q + HALF_FX;
	assign inc      = rnd_sum >> FRAC_BITS;
	assign grow_f   = {1'b0, inc} + (NUM_W+1)'(fcov_q);
	assign grow_w   = {1'b0, inc} + (NUM_W+1)'(wcov_q);
	assign w_drop   = flow_q[VAL_W-1] ? ((NUM_W+2)'(wgt_q) + (NUM_W+2)'(inc))
	                                  : ((NUM_W+2)'(wgt_q) - (NUM_W+2)'(inc));
	assign x_new    = neg_q ? ((DEN_W+2)'(x_sel) - (DEN_W+2)'(div_quot))
	                        : ((DEN_W+2)'(x_sel) + (DEN_W+2)'(div_quot));
	assign div_num  = prod_q + NUM_W'(den_q >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser || s_tdata[159:128] == '0)
						state_d = ST_OUT;
					else
						state_d = ST_MUL_FQ;
				end
			end
			ST_MUL_FQ:  state_d = ST_GROW_F;
			ST_GROW_F:  state_d = ST_MUL_W;
			ST_MUL_W:   state_d = ST_DROP_W;
			ST_DROP_W:  state_d = ST_MUL_WQ;
			ST_MUL_WQ:  state_d = ST_GROW_W;
			ST_GROW_W:  state_d = ST_SENSOR;
			ST_SENSOR:  state_d = (r_sel == '0) ? ST_NEXT : ST_MUL_C;
			ST_MUL_C:   state_d = ST_START_C;
			ST_START_C: state_d = ST_WAIT_C;
			ST_WAIT_C:  state_d = div_done ? ST_UPD_X : ST_WAIT_C;
			ST_UPD_X:   state_d = ST_MUL_P;
			ST_MUL_P:   state_d = ST_START_P;
			ST_START_P: state_d = ST_WAIT_P;
			ST_WAIT_P:  state_d = div_done ? ST_NEXT : ST_WAIT_P;
			ST_NEXT:    state_d = (k_q == SNS_WGT_B) ? ST_CLAMP : ST_SENSOR;
			ST_CLAMP:   state_d = ST_OUT;
			ST_OUT:     state_d = m_tready ? ST_IDLE : ST_OUT;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		unique case (state_q)
			ST_IDLE:    s_tready = 1'b1;
			ST_MUL_FQ:  begin mul_a = DEN_W'(fq_q); mul_b = dt_q; end
			ST_MUL_W:   begin mul_a = DEN_W'(flow_abs); mul_b = dt_q; end
			ST_MUL_WQ:  begin mul_a = DEN_W'(wq_q); mul_b = dt_q; end
			ST_MUL_C:   begin mul_a = mag_q; mul_b = p_sel; end
			ST_MUL_P:   begin mul_a = DEN_W'(p_sel); mul_b = r_sel; end
			ST_START_C: div_start = 1'b1;
			ST_START_P: div_start = 1'b1;
			ST_OUT:     m_tvalid = 1'b1;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fq_q    <= VAL_W'(655);
			ra_f_q  <= VAL_W'(65536);
			rb_f_q  <= VAL_W'(65536);
			wq_q    <= VAL_W'(655);
			ra_w_q  <= VAL_W'(65536);
			rb_w_q  <= VAL_W'(65536);
			flow_q  <= '0;
			wgt_q   <= '0;
			fcov_q  <= ONE_FX;
			wcov_q  <= TEN_FX;
			k_q     <= SNS_FLOW_A;
			skip_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FLOW_Q:  fq_q   <= cfg_data;
					REG_FLOW_RA: ra_f_q <= cfg_data;
					REG_FLOW_RB: rb_f_q <= cfg_data;
					REG_WGT_Q:   wq_q   <= cfg_data;
					REG_WGT_RA:  ra_w_q <= cfg_data;
					REG_WGT_RB:  rb_w_q <= cfg_data;
					default:     ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					k_q <= SNS_FLOW_A;
					if (accept) begin
						skip_q <= !s_tuser && (s_tdata[159:128] == '0);
						if (s_tuser) begin
							flow_q <= s_tdata[31:0];
							wgt_q  <= s_tdata[95] ? '0 : s_tdata[95:64];
							fcov_q <= TENTH_FX;
							wcov_q <= ONE_FX;
						end
					end
				end
				ST_GROW_F: fcov_q <= (grow_f[NUM_W:VAL_W] != '0) ? '1 : grow_f[VAL_W-1:0];
				ST_GROW_W: wcov_q <= (grow_w[NUM_W:VAL_W] != '0) ? '1 : grow_w[VAL_W-1:0];
				ST_DROP_W: begin
					if (w_drop < 0)
						wgt_q <= '0;
					else if (w_drop > (NUM_W+2)'(WGT_MAX))
						wgt_q <= WGT_MAX[VAL_W-1:0];
					else
						wgt_q <= w_drop[VAL_W-1:0];
				end
				ST_UPD_X: begin
					if (k_q[1])
						wgt_q <= x_new[VAL_W-1:0];
					else
						flow_q <= x_new[VAL_W-1:0];
				end
				ST_WAIT_P: begin
					if (div_done) begin
						if (k_q[1])
							wcov_q <= div_quot[VAL_W-1:0];
						else
							fcov_q <= div_quot[VAL_W-1:0];
					end
				end
				ST_NEXT:  k_q <= k_q + 2'd1;
				ST_CLAMP: if (wgt_q[VAL_W-1]) wgt_q <= '0;
				default:  ;
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			fa_q <= s_tdata[31:0];
			fb_q <= s_tdata[63:32];
			wa_q <= s_tdata[95:64];
			wb_q <= s_tdata[127:96];
			dt_q <= s_tdata[159:128];
		end
		if (state_q == ST_SENSOR) begin
			den_q <= DEN_W'(p_sel) + DEN_W'(r_sel);
			neg_q <= d_val[DEN_W-1];
			mag_q <= d_val[DEN_W-1] ? DEN_W'(-d_val) : DEN_W'(d_val);
		end
		prod_q <= NUM_W'(mul_a) * NUM_W'(mul_b);
	end

	kfus_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign m_tdata = {1'b0, wcov_q, fcov_q, wgt_q[WGT_W-1:0], flow_q};
	assign m_tuser = skip_q;

	a_ready_xor_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_WAIT_C || state_q == ST_WAIT_P))
		else $error("divider busy outside a wait state");

	a_weight_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !wgt_q[VAL_W-1])
		else $error("negative weight at output");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |=> !div_done)
		else $error("divider done held more than one cycle");

endmodule

`default_nettype wire

@@ sv/kfus_div.sv @@
// kfus_div: restoring divider, one quotient bit per cycle
// quotient must fit QUO_W bits; depends on kfus_pkg
`default_nettype none

module kfus_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [kfus_pkg::NUM_W-1:0] num,
	input  wire logic [kfus_pkg::DEN_W-1:0] den,
	output logic                            busy,
	output logic                            done,
	output logic [kfus_pkg::QUO_W-1:0]      quot
);
	import kfus_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] low_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, low_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[NUM_W-1:QUO_W]};
			low_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = low_q;

endmodule

`default_nettype wire

@@ tb/two_sensor_kalman_fusion_test.sv @@
// two_sensor_kalman_fusion_test: self-checking bench for the two-sensor kalman fusion block
// drives measurement items with random gaps and noise settings, checks results against a predictor
// depends on kfus_pkg and two_sensor_kalman_fusion
`timescale 1ns / 1ps

module two_sensor_kalman_fusion_test;
	import kfus_pkg::*;

	localparam int FRAC = 16;
	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_INIT = 1'b1;

	typedef struct packed {
		logic [31:0] flow;
		logic [30:0] weight;
		logic [31:0] fvar;
		logic [31:0] wvar;
		logic        skip;
	} fusion_out_t;

	typedef struct {
		logic        func;
		logic [31:0] fa, fb, wa, wb, dt;
		logic        has_exp;
		fusion_out_t exp;
	} meas_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         m_tuser;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;

	two_sensor_kalman_fusion i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] noise_reg [0:5];
	longint      flow_est, wgt_est;
	logic [63:0] flow_var, wgt_var;

	fusion_out_t expected_q [$];
	int          mismatches;
	bit          hold_req;
	bit          quiet;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] grow_variance(logic [63:0] p, logic [63:0] q,
			logic [63:0] dt);
		logic [63:0] inc;
		logic [63:0] s;
		inc = (q * dt + 64'd32768) >> FRAC;
		s = p + inc;
		return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
	endfunction

	function automatic longint flow_times_dt(longint a, logic [63:0] b);
		logic [63:0] mag;
		logic [63:0] r;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		r = (mag * b + 64'd32768) >> FRAC;
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp_weight(longint w);
		if (w < 0) return 0;
		if (w > 64'h7FFF_FFFF) return 64'h7FFF_FFFF;
		return w;
	endfunction

	task automatic kalman_gain(inout longint x, inout logic [63:0] p, input longint m,
			input logic [63:0] r);
		logic [63:0] den, mag, c;
		longint d;
		if (r == 0) return;
		den = p + r;
		d = m - x;
		mag = (d < 0) ? 64'(-d) : 64'(d);
		c = (mag * p + den / 2) / den;
		x = (d < 0) ? x - longint'(c) : x + longint'(c);
		p = (p * r + den / 2) / den;
	endtask

	task automatic fuse_step(input logic func, input logic [31:0] fa, fb, wa, wb, dt,
			output fusion_out_t r);
		logic skip;
		skip = 1'b0;
		if (func == FUNC_INIT) begin
			flow_est = longint'($signed(fa));
			flow_var = ((64'd1 << FRAC) + 5) / 10;
			wgt_est = clamp_weight(longint'($signed(wa)));
			wgt_var = 64'd1 << FRAC;
		end else if (dt == 0) begin
			skip = 1'b1;
		end else begin
			flow_var = grow_variance(flow_var, noise_reg[REG_FLOW_Q], dt);
			wgt_est = clamp_weight(wgt_est - flow_times_dt(flow_est, dt));
			wgt_var = grow_variance(wgt_var, noise_reg[REG_WGT_Q], dt);
			kalman_gain(flow_est, flow_var, longint'($signed(fa)), noise_reg[REG_FLOW_RA]);
			kalman_gain(flow_est, flow_var, longint'($signed(fb)), noise_reg[REG_FLOW_RB]);
			kalman_gain(wgt_est, wgt_var, longint'($signed(wa)), noise_reg[REG_WGT_RA]);
			kalman_gain(wgt_est, wgt_var, longint'($signed(wb)), noise_reg[REG_WGT_RB]);
			wgt_est = clamp_weight(wgt_est);
		end
		r.flow = flow_est[31:0];
		r.weight = wgt_est[30:0];
		r.fvar = flow_var[31:0];
		r.wvar = wgt_var[31:0];
		r.skip = skip;
	endtask

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_noise(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		if (idx <= REG_WGT_RB)
			noise_reg[idx] = val;
	endtask

	// sender: called at a falling edge, returns at a falling edge after the accept
	task automatic send_item(input meas_row_t row);
		fusion_out_t r;
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= row.func;
		s_tdata <= {row.dt, row.wb, row.wa, row.fb, row.fa};
		#1;
		while (!s_tready) @(negedge clk);
		fuse_step(row.func, row.fa, row.fb, row.wa, row.wb, row.dt, r);
		expected_q.push_back(row.has_exp ? row.exp : r);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_noise();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			3: return $urandom_range(1, 255);
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	function automatic meas_row_t rand_item();
		meas_row_t row;
		row.has_exp = 1'b0;
		row.exp = '0;
		row.func = ($urandom_range(0, 11) == 0) ? FUNC_INIT : FUNC_UPDATE;
		if ($urandom_range(0, 6) == 0) begin
			row.fa = $urandom();
			row.fb = $urandom();
			row.wa = $urandom();
			row.wb = $urandom();
			row.dt = $urandom();
		end else begin
			row.fa = $urandom_range(0, 40 << FRAC) - (20 << FRAC);
			row.fb = $urandom_range(0, 40 << FRAC) - (20 << FRAC);
			row.wa = $urandom_range(0, 1010 << FRAC) - (10 << FRAC);
			row.wb = $urandom_range(0, 1010 << FRAC) - (10 << FRAC);
			row.dt = $urandom_range(1, 4 << FRAC);
		end
		case ($urandom_range(0, 19))
			0: row.dt = 32'd0;
			1: row.dt = 32'hFFFF_FFFF;
			default: ;
		endcase
		return row;
	endfunction

	meas_row_t directed [] = '{
		'{FUNC_UPDATE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1,
			'{32'd0, 31'd0, 32'd65536, 32'd655360, 1'b1}},
		'{FUNC_INIT, 32'h8000_0000, 32'h1234_5678, 32'hFFFB_0000, 32'd7, 32'd99, 1'b1,
			'{32'h8000_0000, 31'd0, 32'd6554, 32'd65536, 1'b0}},
		'{FUNC_UPDATE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h2, 32'd0, 1'b1,
			'{32'h8000_0000, 31'd0, 32'd6554, 32'd65536, 1'b1}},
		'{FUNC_INIT, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1,
			'{32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd6554, 32'd65536, 1'b0}},
		'{FUNC_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 1'b0, '0},
		'{FUNC_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd1, 1'b0, '0},
		'{FUNC_INIT, 32'h000A_0000, 32'd0, 32'h01F4_0000, 32'd0, 32'd0, 1'b0, '0},
		'{FUNC_UPDATE, 32'h000A_8000, 32'h0009_8000, 32'h01EA_0000, 32'h01EB_0000,
			32'h0001_0000, 1'b0, '0},
		'{FUNC_UPDATE, 32'hFFFF_0000, 32'h0001_0000, 32'h01E0_0000, 32'h01D0_0000,
			32'h0000_8000, 1'b0, '0},
		'{FUNC_UPDATE, 32'h0, 32'h0, 32'hFFF0_0000, 32'hFFF0_0000, 32'h0100_0000, 1'b0, '0},
		'{FUNC_INIT, 32'hFFF6_0000, 32'd0, 32'h0000_0001, 32'd0, 32'd0, 1'b0, '0},
		'{FUNC_UPDATE, 32'hFFF6_0000, 32'hFFF5_0000, 32'h0, 32'h0, 32'h0003_0000, 1'b0, '0},
		'{FUNC_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'hAAAA_AAAA, 1'b0, '0},
		'{FUNC_UPDATE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h5555_5555, 1'b0, '0}
	};

	// receiver
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				gap = 400;
				hold_req = 1'b0;
			end else begin
				gap = quiet ? 0 : $urandom_range(0, 7);
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			while (!m_tvalid) @(negedge clk);
			@(negedge clk);
		end
	end

	// result check
	always @(posedge clk) begin
		fusion_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[62:32], m_tdata[94:63], m_tdata[126:95], m_tuser};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", got);
			end else begin
				want = expected_q.pop_front();
				if (got.flow !== want.flow || got.weight !== want.weight ||
						got.fvar !== want.fvar || got.wvar !== want.wvar ||
						got.skip !== want.skip) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result: flow %h/%h weight %h/%h fvar %h/%h wvar %h/%h skip %b/%b",
							want.flow, got.flow, want.weight, got.weight, want.fvar, got.fvar,
							want.wvar, got.wvar, want.skip, got.skip);
				end
			end
		end
	end

	initial begin
		#30ms;
		$display("two_sensor_kalman_fusion: mismatch");
		$finish;
	end

	initial begin
		mismatches = 0;
		hold_req = 1'b0;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		noise_reg = '{32'd655, 32'd65536, 32'd65536, 32'd655, 32'd65536, 32'd65536};
		flow_est = 0;
		wgt_est = 0;
		flow_var = 64'd1 << FRAC;
		wgt_var = 64'd10 << FRAC;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_item(directed[i]);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph)
				0: for (int k = 0; k < 6; k++) write_noise(3'(k), 32'd0);
				1: for (int k = 0; k < 6; k++) write_noise(3'(k), 32'hFFFF_FFFF);
				2: begin
					write_noise(REG_FLOW_Q, 32'd655);
					write_noise(REG_FLOW_RA, 32'h0001_0000);
					write_noise(REG_FLOW_RB, 32'd0);
					write_noise(REG_WGT_Q, 32'd655);
					write_noise(REG_WGT_RA, 32'd0);
					write_noise(REG_WGT_RB, 32'h0002_0000);
				end
				3: begin
					write_noise(3'd6, $urandom());
					write_noise(3'd7, $urandom());
					for (int k = 0; k < 6; k++) write_noise(3'(k), 32'd1);
				end
				default: for (int k = 0; k < 6; k++) write_noise(3'(k), rand_noise());
			endcase
			cfg_we <= 1'b0;
			quiet = (ph == 4);
			if (ph == 5) hold_req = 1'b1;
			for (int n = 0; n < 150; n++)
				send_item(rand_item());
		end

		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("two_sensor_kalman_fusion: match");
		else
			$display("two_sensor_kalman_fusion: mismatch");
		$finish;
	end

endmodule
